FILE: design/assert_macros.svh
// assertion macros shared by the rtl
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked on every rising clock edge outside reset
`define ASSERT_IMPL(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
// next-cycle implication checked outside reset
`define ASSERT_NEXT(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`endif

FILE: design/xalu_pkg.sv
// package for the x86 integer alu: command codes, widths, states
// no dependencies
package xalu_pkg;
  typedef enum logic [3:0] {
    CMD_ADD = 4'd0, CMD_SUB = 4'd1, CMD_CMP = 4'd2, CMD_INC = 4'd3,
    CMD_DEC = 4'd4, CMD_NEG = 4'd5, CMD_ADC = 4'd6, CMD_SBB = 4'd7,
    CMD_MUL = 4'd8, CMD_IMUL1 = 4'd9, CMD_IMUL2 = 4'd10, CMD_IMUL3 = 4'd11,
    CMD_DIV = 4'd12, CMD_IDIV = 4'd13
  } cmd_t;

  localparam logic [1:0] WC_BYTE = 2'd0;
  localparam logic [1:0] WC_WORD = 2'd1;

  localparam logic [1:0] TGT_NONE = 2'd0;
  localparam logic [1:0] TGT_DEST = 2'd1;
  localparam logic [1:0] TGT_ACC  = 2'd2;

  localparam int IN_BITS  = 168;
  localparam int OUT_BITS = 72;
  localparam int DIV_STEPS = 64;

  typedef enum logic [2:0] {
    ST_IDLE, ST_PREP, ST_MULT, ST_DIV, ST_FIN, ST_OUT
  } state_t;

  // control from sequencer to shared divider
  typedef struct packed {
    logic start;
    logic step;
  } div_ctl_t;

  function automatic logic [31:0] wmask(input logic [1:0] wc);
    case (wc)
      WC_BYTE: wmask = 32'h0000_00ff;
      WC_WORD: wmask = 32'h0000_ffff;
      default: wmask = 32'hffff_ffff;
    endcase
  endfunction

  function automatic logic [63:0] sext64(input logic [31:0] v, input logic [1:0] wc);
    case (wc)
      WC_BYTE: sext64 = {{56{v[7]}}, v[7:0]};
      WC_WORD: sext64 = {{48{v[15]}}, v[15:0]};
      default: sext64 = {{32{v[31]}}, v};
    endcase
  endfunction
endpackage

FILE: design/xalu_div.sv
// restoring divider, 64 by 64 bit unsigned, one quotient bit a cycle while step is high
// depends on xalu_pkg
module xalu_div (
  input  logic               clk,
  input  xalu_pkg::div_ctl_t ctl,
  input  logic [63:0]        num,
  input  logic [63:0]        den,
  output logic [63:0]        quo,
  output logic [63:0]        rem
);
  import xalu_pkg::*;

  logic [63:0] q_r, q_nxt, r_r, r_nxt;
  logic [64:0] trial;

  always_comb begin
    q_nxt = q_r;
    r_nxt = r_r;
    trial = {r_r, q_r[63]} - {1'b0, den};
    if (ctl.start) begin
      q_nxt = num;
      r_nxt = '0;
    end else if (ctl.step) begin
      if (!trial[64]) begin
        r_nxt = trial[63:0];
        q_nxt = {q_r[62:0], 1'b1};
      end else begin
        r_nxt = {r_r[62:0], q_r[63]};
        q_nxt = {q_r[62:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
    r_r <= r_nxt;
  end

  assign quo = q_r;
  assign rem = r_r;
endmodule

FILE: design/x86_integer_alu_with_flags_core.sv
// top level of the x86 integer alu with flags
// depends on xalu_pkg, xalu_div and assert_macros.svh
//
// usage
// - input channel in_*: one operation per transfer; in_tdata packs cmd, width_code,
//   dest_operand, src_operand, src2_operand, acc_low, acc_high from bit 0 up
// - result channel out_*: one result per input, out_tdata packs main_value,
//   extra_value, write_target, carry, zero, sign, overflow flags, divide_error
// - one item at a time: in_tready is high only while the sequencer is idle
// - add/sub family: out_tvalid rises after the prepare and finish states
// - multiplies: one 32x32 product through a registered multiplier
// - divides: the shared restoring divider steps once a cycle through 64
//   quotient bits, between the prepare and finish states
// - in_tready returns the cycle after the result transfer
// - flags CF ZF SF OF are kept between items; reset clears them to zero
// - a stalled receiver holds the result in the output register; no new item
//   is taken until that result is transferred
module x86_integer_alu_with_flags_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // cmd[3:0] width_code[5:4] dest[37:6] src[69:38] src2[101:70]
  // acc_low[133:102] acc_high[165:134] zero pad[167:166]
  input  logic [xalu_pkg::IN_BITS-1:0]   in_tdata,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // main_value[31:0] extra_value[63:32] write_target[65:64] carry[66]
  // zero[67] sign[68] overflow[69] divide_error[70] zero pad[71]
  output logic [xalu_pkg::OUT_BITS-1:0]  out_tdata
);
  import xalu_pkg::*;

  state_t state_r, state_nxt;

  // captured item
  logic [3:0]  cmd_r;
  logic [1:0]  wc_r;
  logic [31:0] d_r, s_r, s2_r, alo_r, ahi_r;
  // flags
  logic cf_r, zf_r, sf_r, of_r;
  logic cf_nxt, zf_nxt, sf_nxt, of_nxt;
  // result register
  logic [31:0] main_r, extra_r;
  logic [1:0]  tgt_r;
  logic        derr_r;
  // multiplier operands and product
  logic [63:0] ma_r, mb_r, prod_r;
  // divider set-up
  logic [63:0] dnum_c, dden_r;
  logic        nneg_r, dneg_r;
  logic [6:0]  cnt_r;
  div_ctl_t    dctl;
  logic [63:0] quo, rem;

  xalu_div u_div (
    .clk (clk),
    .ctl (dctl),
    .num (dnum_c),
    .den (dden_r),
    .quo (quo),
    .rem (rem)
  );

  logic [31:0] m, d, s, minv, rr;
  logic [32:0] sum;
  logic        isdiv, ismul;
  logic [31:0] mainc, extrac;
  logic [1:0]  tgtc;
  logic        derrc;
  logic [63:0] n64, sn, sd, uq, qv, rv;
  logic        qneg, ovf;

  assign m     = wmask(wc_r);
  assign d     = d_r & m;
  assign s     = s_r & m;
  assign minv  = (wc_r == WC_BYTE) ? 32'h80 : (wc_r == WC_WORD) ? 32'h8000 : 32'h8000_0000;
  assign isdiv = (cmd_r == CMD_DIV) || (cmd_r == CMD_IDIV);
  assign ismul = (cmd_r == CMD_MUL) || (cmd_r == CMD_IMUL1) ||
                 (cmd_r == CMD_IMUL2) || (cmd_r == CMD_IMUL3);

  // sign bit at the operand width
  function automatic logic topb(input logic [31:0] v, input logic [1:0] wc);
    case (wc)
      WC_BYTE: topb = v[7];
      WC_WORD: topb = v[15];
      default: topb = v[31];
    endcase
  endfunction

  // dividend assembly and signed magnitudes
  always_comb begin
    case (wc_r)
      WC_BYTE: n64 = {48'd0, alo_r[15:0]};
      WC_WORD: n64 = {32'd0, ahi_r[15:0], alo_r[15:0]};
      default: n64 = {ahi_r, alo_r};
    endcase
    case (wc_r)
      WC_BYTE: sn = {{48{n64[15]}}, n64[15:0]};
      WC_WORD: sn = {{32{n64[31]}}, n64[31:0]};
      default: sn = n64;
    endcase
    sd = sext64(d, wc_r);
    // numerator handed to the divider as it starts
    if (cmd_r == CMD_IDIV) dnum_c = sn[63] ? (64'd0 - sn) : sn;
    else                   dnum_c = n64;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_tvalid) state_nxt = ST_PREP;
      ST_PREP: begin
        if (ismul)      state_nxt = ST_MULT;
        else if (isdiv) state_nxt = ST_DIV;
        else            state_nxt = ST_FIN;
      end
      ST_MULT: state_nxt = ST_FIN;
      ST_DIV:  if (cnt_r == 7'(DIV_STEPS - 1)) state_nxt = ST_FIN;
      ST_FIN:  state_nxt = ST_OUT;
      ST_OUT:  if (out_tready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_tready  = (state_r == ST_IDLE);
    out_tvalid = (state_r == ST_OUT);
    dctl.start = (state_r == ST_PREP) && isdiv;
    dctl.step  = (state_r == ST_DIV);
  end

  // result and flag computation in the finish cycle
  always_comb begin
    mainc  = '0;
    extrac = '0;
    tgtc   = TGT_NONE;
    derrc  = 1'b0;
    cf_nxt = cf_r; zf_nxt = zf_r; sf_nxt = sf_r; of_nxt = of_r;
    sum    = '0;
    rr     = '0;
    qneg   = nneg_r ^ dneg_r;
    uq     = quo;
    qv     = qneg ? (64'd0 - uq) : uq;
    rv     = nneg_r ? (64'd0 - rem) : rem;
    ovf    = 1'b0;
    case (cmd_r)
      CMD_ADD, CMD_ADC: begin
        sum = {1'b0, d} + {1'b0, s} + {32'd0, (cmd_r == CMD_ADC) & cf_r};
        rr  = sum[31:0] & m;
        cf_nxt = (wc_r == WC_BYTE) ? sum[8] : (wc_r == WC_WORD) ? sum[16] : sum[32];
        of_nxt = topb(~(d ^ s) & (d ^ rr), wc_r);
        zf_nxt = (rr == 32'd0); sf_nxt = topb(rr, wc_r);
        mainc = rr; tgtc = TGT_DEST;
      end
      CMD_SUB, CMD_CMP, CMD_SBB: begin
        sum = {1'b0, s} + {32'd0, (cmd_r == CMD_SBB) & cf_r};
        rr  = (d - s - {31'd0, (cmd_r == CMD_SBB) & cf_r}) & m;
        cf_nxt = {1'b0, d} < sum;
        of_nxt = topb((d ^ s) & (d ^ rr), wc_r);
        zf_nxt = (rr == 32'd0); sf_nxt = topb(rr, wc_r);
        if (cmd_r != CMD_CMP) begin
          mainc = rr; tgtc = TGT_DEST;
        end
      end
      CMD_INC: begin
        rr = (d + 32'd1) & m;
        of_nxt = (d == minv - 32'd1);
        zf_nxt = (rr == 32'd0); sf_nxt = topb(rr, wc_r);
        mainc = rr; tgtc = TGT_DEST;
      end
      CMD_DEC: begin
        rr = (d - 32'd1) & m;
        of_nxt = (d == minv);
        zf_nxt = (rr == 32'd0); sf_nxt = topb(rr, wc_r);
        mainc = rr; tgtc = TGT_DEST;
      end
      CMD_NEG: begin
        rr = (32'd0 - d) & m;
        cf_nxt = (d != 32'd0);
        of_nxt = (d == minv);
        zf_nxt = (rr == 32'd0); sf_nxt = topb(rr, wc_r);
        mainc = rr; tgtc = TGT_DEST;
      end
      CMD_MUL, CMD_IMUL1: begin
        mainc = prod_r[31:0] & m;
        case (wc_r)
          WC_BYTE: extrac = {24'd0, prod_r[15:8]};
          WC_WORD: extrac = {16'd0, prod_r[31:16]};
          default: extrac = prod_r[63:32];
        endcase
        tgtc = TGT_ACC;
      end
      CMD_IMUL2, CMD_IMUL3: begin
        mainc = prod_r[31:0] & m;
        tgtc  = TGT_DEST;
      end
      CMD_DIV: begin
        if (dden_r == 64'd0 || quo > {32'd0, m}) derrc = 1'b1;
        else begin
          mainc = quo[31:0]; extrac = rem[31:0]; tgtc = TGT_ACC;
        end
      end
      CMD_IDIV: begin
        ovf = qneg ? (uq > {32'd0, minv}) : (uq > {32'd0, minv - 32'd1});
        if (dden_r == 64'd0 || ovf) derrc = 1'b1;
        else begin
          mainc = qv[31:0] & m; extrac = rv[31:0] & m; tgtc = TGT_ACC;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cf_r <= 1'b0; zf_r <= 1'b0; sf_r <= 1'b0; of_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_FIN) begin
        cf_r <= cf_nxt; zf_r <= zf_nxt; sf_r <= sf_nxt; of_r <= of_nxt;
      end
      if (state_r == ST_PREP) cnt_r <= '0;
      else if (state_r == ST_DIV) cnt_r <= cnt_r + 7'd1;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_tvalid) begin
      cmd_r <= in_tdata[3:0];
      wc_r  <= in_tdata[5:4];
      d_r   <= in_tdata[37:6];
      s_r   <= in_tdata[69:38];
      s2_r  <= in_tdata[101:70];
      alo_r <= in_tdata[133:102];
      ahi_r <= in_tdata[165:134];
    end
    if (state_r == ST_PREP) begin
      // multiplier operands: signed forms use sign-extended 32-bit values
      case (cmd_r)
        CMD_MUL: begin
          ma_r <= {32'd0, alo_r & m}; mb_r <= {32'd0, d};
        end
        CMD_IMUL1: begin
          ma_r <= sext64(alo_r, wc_r); mb_r <= sext64(d, wc_r);
        end
        CMD_IMUL2: begin
          ma_r <= sext64(d, wc_r); mb_r <= sext64(s, wc_r);
        end
        default: begin
          ma_r <= sext64(s2_r & m, wc_r); mb_r <= sext64(s, wc_r);
        end
      endcase
      nneg_r <= (cmd_r == CMD_IDIV) & sn[63];
      dneg_r <= (cmd_r == CMD_IDIV) & sd[63];
      if (cmd_r == CMD_IDIV) begin
        dden_r <= sd[63] ? (64'd0 - sd) : sd;
      end else begin
        dden_r <= {32'd0, d};
      end
    end
    if (state_r == ST_MULT) begin
      // 33x33 signed product covers both unsigned and signed 32-bit forms
      prod_r <= 64'($signed({(cmd_r != CMD_MUL) & ma_r[31], ma_r[31:0]}) *
                    $signed({(cmd_r != CMD_MUL) & mb_r[31], mb_r[31:0]}));
    end
    if (state_r == ST_FIN) begin
      main_r <= mainc; extra_r <= extrac; tgt_r <= tgtc; derr_r <= derrc;
    end
  end

  assign out_tdata = {1'b0, derr_r, of_r, sf_r, zf_r, cf_r, tgt_r, extra_r, main_r};

  `include "assert_macros.svh"

  `ASSERT_IMPL(a_one_side, clk, rst_n, 1'b1, !(in_tready && out_tvalid))
  `ASSERT_IMPL(a_derr_none, clk, rst_n, out_tvalid && derr_r, tgt_r == TGT_NONE)
  `ASSERT_NEXT(a_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
endmodule
